// ----- src/tt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_pkg
// Types, constants and the per-byte transfer planner for the template tag
// transducer.
// ----------------------------------------------------------------------------
package tt_pkg;

  // template context, one-hot
  typedef enum logic [3:0] {
    M_TEXT    = 4'b0001,
    M_EVAL    = 4'b0010,
    M_PRINT   = 4'b0100,
    M_COMMENT = 4'b1000
  } mode_t;

  typedef enum logic [1:0] {
    CL_NONE  = 2'd0,
    CL_TEXT  = 2'd1,
    CL_PRINT = 2'd2,
    CL_NL    = 2'd3
  } close_t;

  // emit phases, in output order
  localparam int PH_CL1  = 0;
  localparam int PH_HDR  = 1;
  localparam int PH_PFX  = 2;
  localparam int PH_AESC = 3;
  localparam int PH_A    = 4;
  localparam int PH_BESC = 5;
  localparam int PH_B    = 6;
  localparam int PH_CL2  = 7;
  localparam int NUM_PH  = 8;

  localparam int HDR_LEN = 14;
  localparam int PFX_LEN = 12;
  localparam int CL_LEN  = 3;

  // header line, first character in the top byte, ends in a newline
  localparam logic [8*HDR_LEN-1:0] HDR_STR = 112'h7365_6E64_5F68_6561_6465_7273_210A;
  localparam logic [8*PFX_LEN-1:0] PFX_STR = "@out.write((";

  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef struct packed {
    mode_t mode;
    logic  held;
    logic  after_open;
    logic  seg;
    logic  hdr_sent;
  } state_t;

  // what one input byte produces
  typedef struct packed {
    logic [NUM_PH-1:0] mask;
    close_t            close1;
    close_t            close2;
    logic              pfx_print;
    logic [7:0]        a_byte;
    logic [7:0]        b_byte;
    logic              eos;
  } plan_t;

  typedef struct packed {
    state_t st;
    plan_t  pl;
  } step_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } out_item_t;

  localparam state_t STATE_RESET = '{mode: M_TEXT, held: 1'b0, after_open: 1'b0,
                                     seg: 1'b0, hdr_sent: 1'b0};

  function automatic step_t content_f(step_t s, logic [7:0] c);
    step_t r;
    logic  esc;
    r   = s;
    esc = (s.st.mode == M_TEXT) && (c == CH_APOS);
    if (s.st.mode != M_COMMENT) begin
      if (!s.st.seg) begin
        if ((s.st.mode == M_TEXT || s.st.mode == M_PRINT) && !s.st.hdr_sent) begin
          r.pl.mask[PH_HDR] = 1'b1;
          r.st.hdr_sent     = 1'b1;
        end
        if (s.st.mode == M_TEXT || s.st.mode == M_PRINT) begin
          r.pl.mask[PH_PFX] = 1'b1;
          r.pl.pfx_print    = (s.st.mode == M_PRINT);
        end
        r.st.seg = 1'b1;
      end
      if (!s.pl.mask[PH_A]) begin
        r.pl.mask[PH_A]    = 1'b1;
        r.pl.mask[PH_AESC] = esc;
        r.pl.a_byte        = c;
      end else begin
        r.pl.mask[PH_B]    = 1'b1;
        r.pl.mask[PH_BESC] = esc;
        r.pl.b_byte        = c;
      end
    end
    return r;
  endfunction

  function automatic step_t close_f(step_t s, logic second);
    step_t  r;
    close_t k;
    r = s;
    if (s.st.mode == M_TEXT) begin
      k = CL_TEXT;
    end else if (s.st.mode == M_PRINT) begin
      k = CL_PRINT;
    end else begin
      k = CL_NL;
    end
    if (s.st.seg) begin
      if (second) begin
        r.pl.mask[PH_CL2] = 1'b1;
        r.pl.close2       = k;
      end else begin
        r.pl.mask[PH_CL1] = 1'b1;
        r.pl.close1       = k;
      end
    end
    r.st.seg = 1'b0;
    return r;
  endfunction

  function automatic step_t step_f(state_t st, logic [7:0] c, logic last);
    step_t r;
    r.st        = st;
    r.pl.mask   = '0;
    r.pl.close1 = CL_NONE;
    r.pl.close2 = CL_NONE;
    r.pl.pfx_print = 1'b0;
    r.pl.a_byte = '0;
    r.pl.b_byte = '0;
    r.pl.eos    = last;
    if (st.mode == M_TEXT) begin
      if (st.held && c == CH_PCT) begin
        r.st.held       = 1'b0;
        r               = close_f(r, 1'b0);
        r.st.mode       = M_EVAL;
        r.st.after_open = 1'b1;
      end else begin
        if (st.held) begin
          r = content_f(r, CH_LT);
        end
        r.st.held = 1'b0;
        if (c == CH_LT) begin
          r.st.held = 1'b1;
        end else begin
          r = content_f(r, c);
        end
      end
    end else if (st.after_open) begin
      r.st.after_open = 1'b0;
      if (c == CH_HASH) begin
        r.st.mode = M_COMMENT;
      end else if (c == CH_EQ) begin
        r.st.mode = M_PRINT;
      end else if (c == CH_PCT) begin
        r.st.held = 1'b1;
      end else begin
        r = content_f(r, c);
      end
    end else if (st.held && c == CH_GT) begin
      r.st.held = 1'b0;
      r         = close_f(r, 1'b0);
      r.st.mode = M_TEXT;
    end else begin
      if (st.held) begin
        r = content_f(r, CH_PCT);
      end
      r.st.held = 1'b0;
      if (c == CH_PCT) begin
        r.st.held = 1'b1;
      end else begin
        r = content_f(r, c);
      end
    end

    if (last) begin
      if (r.st.held) begin
        r = content_f(r, (r.st.mode == M_TEXT) ? CH_LT : CH_PCT);
      end
      r.st.held = 1'b0;
      r         = close_f(r, 1'b1);
      r.st      = STATE_RESET;
    end
    return r;
  endfunction

  function automatic logic [3:0] close_len(close_t k);
    logic [3:0] n;
    case (k)
      CL_TEXT:  n = 4'(CL_LEN);
      CL_PRINT: n = 4'(CL_LEN);
      default:  n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] close_char(close_t k, logic [3:0] i);
    logic [7:0] ch;
    case (k)
      CL_TEXT: begin
        case (i)
          4'd0:    ch = CH_APOS;
          4'd1:    ch = CH_RPAR;
          default: ch = CH_NL;
        endcase
      end
      CL_PRINT: begin
        case (i)
          4'd0:    ch = CH_RPAR;
          4'd1:    ch = CH_RPAR;
          default: ch = CH_NL;
        endcase
      end
      default: ch = CH_NL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] hdr_char(logic [3:0] i);
    return HDR_STR[8*(HDR_LEN-1-int'(i)) +: 8];
  endfunction

  // text and print prefixes differ only in the last character
  function automatic logic [7:0] pfx_char(logic print, logic [3:0] i);
    logic [7:0] ch;
    ch = PFX_STR[8*(PFX_LEN-1-int'(i)) +: 8];
    if (!print && int'(i) == PFX_LEN-1) begin
      ch = CH_APOS;
    end
    return ch;
  endfunction

endpackage

// ----- src/tt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_in_if
// Template byte channel: valid/ready with source byte and end marker.
// ----------------------------------------------------------------------------
interface tt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_source;

  modport source (output valid, output in_byte, output end_of_source, input ready);
  modport sink   (input valid, input in_byte, input end_of_source, output ready);
endinterface

// ----- src/tt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_out_if
// Script byte channel: valid/ready with output byte and run markers.
// ----------------------------------------------------------------------------
interface tt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

// ----- src/template_tag_transducer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// template_tag_transducer_top
// Turns template source bytes into generated script bytes.
// ----------------------------------------------------------------------------
// An input byte's plan is registered in the sequencer, each script byte in the output buffer.
// Throughput: one script byte per cycle while script_out is not stalled; the sequencer takes
//   the next input byte as it emits the last script byte, so plain text runs at 1 byte/cycle.
// Bursts come from header, prefix and closing strings, up to 32 bytes per input byte.
// Reset (rst, synchronous): text context, no held delimiter, header not yet sent,
//   sequencer and output buffer empty.
module template_tag_transducer_top
  import tt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  tt_in_if.sink   byte_in,
  tt_out_if.source script_out
);

  state_t     st;
  step_t      step;
  plan_t      act;
  logic [3:0] idx;

  logic [NUM_PH-1:0] cur_oh;
  logic [2:0]        ph;
  logic [3:0]        cur_len;
  logic [7:0]        cur_byte;
  logic              phase_done;
  logic              seq_last;
  logic              emit;
  logic              skid_ready;
  logic              accept;
  out_item_t         item;

  assign step = step_f(st, byte_in.in_byte, byte_in.end_of_source);

  // lowest pending phase
  assign cur_oh = act.mask & (~act.mask + NUM_PH'(1));

  always_comb begin
    ph = '0;
    for (int i = 0; i < NUM_PH; i++) begin
      if (cur_oh[i]) ph = 3'(i);
    end
  end

  always_comb begin
    case (ph)
      3'(PH_CL1): begin
        cur_len  = close_len(act.close1);
        cur_byte = close_char(act.close1, idx);
      end
      3'(PH_HDR): begin
        cur_len  = 4'(HDR_LEN);
        cur_byte = hdr_char(idx);
      end
      3'(PH_PFX): begin
        cur_len  = 4'(PFX_LEN);
        cur_byte = pfx_char(act.pfx_print, idx);
      end
      3'(PH_AESC), 3'(PH_BESC): begin
        cur_len  = 4'd1;
        cur_byte = CH_BSL;
      end
      3'(PH_A): begin
        cur_len  = 4'd1;
        cur_byte = act.a_byte;
      end
      3'(PH_B): begin
        cur_len  = 4'd1;
        cur_byte = act.b_byte;
      end
      default: begin
        cur_len  = close_len(act.close2);
        cur_byte = close_char(act.close2, idx);
      end
    endcase
  end

  assign phase_done = (idx == cur_len - 4'd1);
  assign seq_last   = phase_done && ((act.mask & ~cur_oh) == '0);
  assign emit       = (act.mask != '0) && skid_ready;
  assign byte_in.ready = (act.mask == '0) || (emit && seq_last);
  assign accept     = byte_in.valid && byte_in.ready;

  assign item.out_byte    = cur_byte;
  assign item.run_last    = seq_last;
  assign item.stream_done = seq_last && act.eos;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= STATE_RESET;
      act.mask <= '0;
      idx      <= '0;
    end else begin
      if (accept) begin
        st  <= step.st;
        act <= step.pl;
        idx <= '0;
      end else if (emit) begin
        if (phase_done) begin
          act.mask <= act.mask & ~cur_oh;
          idx      <= '0;
        end else begin
          idx <= idx + 4'd1;
        end
      end
    end
  end

  tt_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (emit),
    .up_ready (skid_ready),
    .up_item  (item),
    .dn       (script_out)
  );

endmodule

// ----- src/tt_skid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_skid
// Two-entry output buffer; upstream ready comes from a register only.
// ----------------------------------------------------------------------------
module tt_skid
  import tt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  out_item_t up_item,
  tt_out_if.source  dn
);

  logic      main_vld;
  out_item_t main_item;
  logic      skid_vld;
  out_item_t skid_item;

  assign up_ready       = !skid_vld;
  assign dn.valid       = main_vld;
  assign dn.out_byte    = main_item.out_byte;
  assign dn.run_last    = main_item.run_last;
  assign dn.stream_done = main_item.stream_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_vld <= 1'b0;
      skid_vld <= 1'b0;
    end else if (dn.ready || !main_vld) begin
      if (skid_vld) begin
        main_item <= skid_item;
        main_vld  <= 1'b1;
        skid_vld  <= 1'b0;
      end else begin
        main_item <= up_item;
        main_vld  <= up_valid;
      end
    end else if (up_valid && !skid_vld) begin
      skid_item <= up_item;
      skid_vld  <= 1'b1;
    end
  end

endmodule

// ----- src/tt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_checker
// Port-level checks for the template tag transducer, bound to the top level.
// ----------------------------------------------------------------------------
module tt_checker
  import tt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_done
);

  // a stalled transfer keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
      && $stable(stream_done))
    else $error("output changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> run_last)
    else $error("stream_done without run_last");

  // every segment close ends in a newline, so does the final byte
  a_done_nl: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> out_byte == CH_NL)
    else $error("final byte is not a newline");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind template_tag_transducer_top tt_checker u_tt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (script_out.valid),
  .out_ready   (script_out.ready),
  .out_byte    (script_out.out_byte),
  .run_last    (script_out.run_last),
  .stream_done (script_out.stream_done)
);
